/* hw/rtl/ffsa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and codes of the first-fit segment allocator
// Segment entry layout, result status codes, controller commands and the
// status bundle that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int W_OFS  = 26;
    localparam int W_ADDR = 25;
    localparam int W_CALC = 28;

    localparam logic [W_OFS-1:0] HEAP_DEFAULT = 26'd33554432;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // one segment of the table
    typedef struct packed {
        logic [W_OFS-1:0] start;
        logic [W_OFS-1:0] bytes;
        logic             used;
    } t_seg;

    // controller to datapath commands
    typedef logic [4:0] t_cmd;
    localparam t_cmd CMD_NOP     = 5'd0;
    localparam t_cmd CMD_INIT    = 5'd1;
    localparam t_cmd CMD_CAPTURE = 5'd2;
    localparam t_cmd CMD_NOFIT   = 5'd3;
    localparam t_cmd CMD_BAD     = 5'd4;
    localparam t_cmd CMD_RD0     = 5'd5;
    localparam t_cmd CMD_NEXT    = 5'd6;
    localparam t_cmd CMD_TAKE    = 5'd7;
    localparam t_cmd CMD_FULL    = 5'd8;
    localparam t_cmd CMD_SPLIT   = 5'd9;
    localparam t_cmd CMD_SHR     = 5'd10;
    localparam t_cmd CMD_SPW1    = 5'd11;
    localparam t_cmd CMD_SPW2    = 5'd12;
    localparam t_cmd CMD_FMATCH  = 5'd13;
    localparam t_cmd CMD_FPREV   = 5'd14;
    localparam t_cmd CMD_FNEXT   = 5'd15;
    localparam t_cmd CMD_FWR     = 5'd16;
    localparam t_cmd CMD_FSHL    = 5'd17;
    localparam t_cmd CMD_FFIN    = 5'd18;
    localparam t_cmd CMD_RESP    = 5'd19;

    // datapath to controller status
    typedef struct packed {
        logic is_free;
        logic addr_null;
        logic zero_size;
        logic used;
        logic fit_whole;
        logic fit_split;
        logic full;
        logic last;
        logic match;
        logic need_shr;
        logic shr_more;
        logic has_shl;
        logic shl_more;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

/* hw/rtl/ffsa_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_dpath: segment table datapath
// Holds the segment memory, the working registers of one request and the
// result register, and carries out one controller command per cycle.
// ----------------------------------------------------------------------------
module ffsa_dpath #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ffsa_pkg::t_cmd             i_cmd,
    output ffsa_pkg::t_dp_status            o_dp_status,
    input  wire logic                       i_cfg_we,
    input  wire logic [ffsa_pkg::W_OFS-1:0] i_cfg_data,
    input  wire logic                       i_req_type,
    input  wire logic [ffsa_pkg::W_OFS-1:0] i_req_size,
    input  wire logic [ffsa_pkg::W_ADDR-1:0] i_req_addr,
    input  wire logic                       i_rsp_stall,
    output logic                            o_rsp_valid,
    output logic [1:0]                      o_status,
    output logic [ffsa_pkg::W_ADDR-1:0]     o_result_addr,
    output logic [ffsa_pkg::W_OFS-1:0]      o_free_bytes
);
    import ffsa_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [W_CALC-1:0] HDR  = W_CALC'(HEADER_BYTES);
    localparam logic [CW:0]       MAXC = (CW+1)'(MAX_SEGMENTS);

    t_seg mem [MAX_SEGMENTS];
    t_seg r_rd;

    logic [W_OFS-1:0]  r_heap, r_free, r_mstart, r_mbytes, r_kbytes;
    logic [CW-1:0]     r_cnt, r_idx, r_k, r_j, r_src, r_dst;
    logic              r_type, r_prevf, r_nextf, r_ovalid;
    logic [W_OFS-1:0]  r_size;
    logic [W_ADDR-1:0] r_addr, r_result;
    logic [1:0]        r_st;

    logic [W_CALC-1:0] need, roomy, rd_bytes, rd_hdr, m_hdr, heap_ext, cfg_ext;
    logic [W_OFS-1:0]  first_heap, first_cfg;
    logic [CW:0]       cnt_x, idx_x, k_x, j_x, src_x, src_calc;
    logic [CW-1:0]     base;
    logic              has_prev, has_next, taken, out_free;

    logic              wr_en, rd_en;
    logic [IW-1:0]     wr_addr, rd_addr;
    t_seg              wr_data;

    // first segment size for the current and a newly written heap
    assign heap_ext   = W_CALC'(r_heap);
    assign cfg_ext    = W_CALC'(i_cfg_data);
    assign first_heap = (heap_ext > HDR) ? W_OFS'(heap_ext - HDR) : '0;
    assign first_cfg  = (cfg_ext > HDR) ? W_OFS'(cfg_ext - HDR) : '0;

    // fit arithmetic
    assign need     = W_CALC'(r_size) + HDR;
    assign roomy    = need + HDR;
    assign rd_bytes = W_CALC'(r_rd.bytes);
    assign rd_hdr   = W_CALC'(r_rd.start) + HDR;
    assign m_hdr    = W_CALC'(r_mstart) + HDR;

    assign cnt_x    = {1'b0, r_cnt};
    assign idx_x    = {1'b0, r_idx};
    assign k_x      = {1'b0, r_k};
    assign j_x      = {1'b0, r_j};
    assign src_x    = {1'b0, r_src};
    assign src_calc = k_x + (CW+1)'(1) + (CW+1)'(r_nextf);
    assign base     = r_prevf ? r_k - CW'(1) : r_k;
    assign has_prev = (r_k != '0);
    assign has_next = (k_x + (CW+1)'(1)) < cnt_x;

    assign taken    = r_ovalid && !i_rsp_stall;
    assign out_free = !r_ovalid || !i_rsp_stall;

    // status towards the controller
    always_comb begin
        o_dp_status.is_free   = r_type;
        o_dp_status.addr_null = (r_addr == '0);
        o_dp_status.zero_size = (r_size == '0);
        o_dp_status.used      = r_rd.used;
        o_dp_status.fit_whole = !r_rd.used && (rd_bytes >= need) && (rd_bytes <= roomy);
        o_dp_status.fit_split = !r_rd.used && (rd_bytes > roomy);
        o_dp_status.full      = (cnt_x >= MAXC);
        o_dp_status.last      = (idx_x + (CW+1)'(1)) == cnt_x;
        o_dp_status.match     = (rd_hdr == W_CALC'(r_addr));
        o_dp_status.need_shr  = cnt_x > (idx_x + (CW+1)'(1));
        o_dp_status.shr_more  = j_x > (k_x + (CW+1)'(2));
        o_dp_status.has_shl   = src_calc < cnt_x;
        o_dp_status.shl_more  = (src_x + (CW+1)'(1)) < cnt_x;
        o_dp_status.out_free  = out_free;
    end

    // memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cfg_we) begin
            wr_en         = 1'b1;
            wr_data.bytes = first_cfg;
        end else begin
            case (i_cmd)
                CMD_INIT: begin
                    wr_en         = 1'b1;
                    wr_data.bytes = first_heap;
                end
                CMD_RD0: begin
                    rd_en = 1'b1;
                end
                CMD_NEXT: begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_idx + CW'(1));
                end
                CMD_TAKE: begin
                    wr_en        = 1'b1;
                    wr_addr      = r_idx[IW-1:0];
                    wr_data      = r_rd;
                    wr_data.used = 1'b1;
                end
                CMD_SPLIT: begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_cnt - CW'(1));
                end
                CMD_SHR: begin
                    wr_en   = 1'b1;
                    wr_addr = r_j[IW-1:0];
                    wr_data = r_rd;
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_j - CW'(2));
                end
                CMD_SPW1: begin
                    wr_en         = 1'b1;
                    wr_addr       = IW'(r_k + CW'(1));
                    wr_data.start = W_OFS'(W_CALC'(r_mstart) + need);
                    wr_data.bytes = W_OFS'(W_CALC'(r_mbytes) - need);
                end
                CMD_SPW2: begin
                    wr_en         = 1'b1;
                    wr_addr       = r_k[IW-1:0];
                    wr_data.start = r_mstart;
                    wr_data.bytes = need[W_OFS-1:0];
                    wr_data.used  = 1'b1;
                end
                CMD_FMATCH: begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_idx - CW'(1));
                end
                CMD_FPREV: begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_k + CW'(1));
                end
                CMD_FWR: begin
                    wr_en         = 1'b1;
                    wr_addr       = base[IW-1:0];
                    wr_data.start = r_mstart;
                    wr_data.bytes = r_mbytes;
                    rd_en         = 1'b1;
                    rd_addr       = src_calc[IW-1:0];
                end
                CMD_FSHL: begin
                    wr_en   = 1'b1;
                    wr_addr = r_dst[IW-1:0];
                    wr_data = r_rd;
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_src + CW'(1));
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // segment memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // control registers: table size, free total, heap, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap   <= HEAP_DEFAULT;
            r_cnt    <= CW'(1);
            r_free   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd == CMD_RESP) begin
                r_ovalid <= 1'b1;
            end else if (taken) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_heap <= i_cfg_data;
                r_cnt  <= CW'(1);
                r_free <= first_cfg;
            end else begin
                case (i_cmd)
                    CMD_INIT: begin
                        r_cnt  <= CW'(1);
                        r_free <= first_heap;
                    end
                    CMD_TAKE: r_free <= r_free - r_rd.bytes;
                    CMD_SPW2: begin
                        r_cnt  <= r_cnt + CW'(1);
                        r_free <= r_free - need[W_OFS-1:0];
                    end
                    CMD_FWR:  r_free <= r_free + r_kbytes;
                    CMD_FFIN: r_cnt <= r_cnt - CW'(r_prevf) - CW'(r_nextf);
                    default:  r_cnt <= r_cnt;
                endcase
            end
        end
    end

    // working registers of the current request
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_CAPTURE: begin
                r_type   <= i_req_type;
                r_size   <= i_req_size;
                r_addr   <= i_req_addr;
                r_st     <= ST_OK;
                r_result <= '0;
            end
            CMD_NOFIT: r_st <= ST_NOFIT;
            CMD_BAD:   r_st <= ST_BAD;
            CMD_FULL:  r_st <= ST_FULL;
            CMD_RD0:   r_idx <= '0;
            CMD_NEXT:  r_idx <= r_idx + CW'(1);
            CMD_TAKE:  r_result <= rd_hdr[W_ADDR-1:0];
            CMD_SPLIT: begin
                r_k      <= r_idx;
                r_j      <= r_cnt;
                r_mstart <= r_rd.start;
                r_mbytes <= r_rd.bytes;
            end
            CMD_SHR:   r_j <= r_j - CW'(1);
            CMD_SPW2:  r_result <= m_hdr[W_ADDR-1:0];
            CMD_FMATCH: begin
                r_k      <= r_idx;
                r_mstart <= r_rd.start;
                r_mbytes <= r_rd.bytes;
                r_kbytes <= r_rd.bytes;
                r_prevf  <= 1'b0;
                r_nextf  <= 1'b0;
            end
            CMD_FPREV: begin
                if (has_prev && !r_rd.used) begin
                    r_prevf  <= 1'b1;
                    r_mstart <= r_rd.start;
                    r_mbytes <= r_mbytes + r_rd.bytes;
                end
            end
            CMD_FNEXT: begin
                if (has_next && !r_rd.used) begin
                    r_nextf  <= 1'b1;
                    r_mbytes <= r_mbytes + r_rd.bytes;
                end
            end
            CMD_FWR: begin
                r_src <= src_calc[CW-1:0];
                r_dst <= base + CW'(1);
            end
            CMD_FSHL: begin
                r_src <= r_src + CW'(1);
                r_dst <= r_dst + CW'(1);
            end
            default: r_st <= r_st;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_RESP) begin
            o_status      <= r_st;
            o_result_addr <= r_result;
            o_free_bytes  <= r_free;
        end
    end

    assign o_rsp_valid = r_ovalid;

endmodule
`default_nettype wire

/* hw/rtl/ffsa_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_ctrl: allocator sequencer
// Steps the datapath through the table walk, the entry shifts of a split or
// a merge, and the hand-over of each result item.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    output logic                      o_req_stall,
    input  wire ffsa_pkg::t_dp_status i_dp_status,
    output ffsa_pkg::t_cmd            o_cmd
);
    import ffsa_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_AEVAL = 4'd3;
    localparam logic [3:0] S_SHR   = 4'd4;
    localparam logic [3:0] S_SPW1  = 4'd5;
    localparam logic [3:0] S_SPW2  = 4'd6;
    localparam logic [3:0] S_FEVAL = 4'd7;
    localparam logic [3:0] S_FPREV = 4'd8;
    localparam logic [3:0] S_FNEXT = 4'd9;
    localparam logic [3:0] S_FWR   = 4'd10;
    localparam logic [3:0] S_FSHL  = 4'd11;
    localparam logic [3:0] S_FFIN  = 4'd12;
    localparam logic [3:0] S_RESP  = 4'd13;

    logic [3:0] r_state, n_state;
    t_dp_status st;

    assign st          = i_dp_status;
    assign o_req_stall = (r_state != S_IDLE);

    // next state and command
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        case (r_state)
            S_INIT: begin
                o_cmd   = CMD_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd   = CMD_CAPTURE;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (st.is_free) begin
                    if (st.addr_null) begin
                        n_state = S_RESP;
                    end else begin
                        o_cmd   = CMD_RD0;
                        n_state = S_FEVAL;
                    end
                end else if (st.zero_size) begin
                    o_cmd   = CMD_NOFIT;
                    n_state = S_RESP;
                end else begin
                    o_cmd   = CMD_RD0;
                    n_state = S_AEVAL;
                end
            end
            S_AEVAL: begin
                if (st.fit_whole) begin
                    o_cmd   = CMD_TAKE;
                    n_state = S_RESP;
                end else if (st.fit_split) begin
                    if (st.full) begin
                        o_cmd   = CMD_FULL;
                        n_state = S_RESP;
                    end else begin
                        o_cmd   = CMD_SPLIT;
                        n_state = st.need_shr ? S_SHR : S_SPW1;
                    end
                end else if (st.last) begin
                    o_cmd   = CMD_NOFIT;
                    n_state = S_RESP;
                end else begin
                    o_cmd = CMD_NEXT;
                end
            end
            S_SHR: begin
                o_cmd = CMD_SHR;
                if (!st.shr_more) begin
                    n_state = S_SPW1;
                end
            end
            S_SPW1: begin
                o_cmd   = CMD_SPW1;
                n_state = S_SPW2;
            end
            S_SPW2: begin
                o_cmd   = CMD_SPW2;
                n_state = S_RESP;
            end
            S_FEVAL: begin
                if (st.match) begin
                    if (!st.used) begin
                        o_cmd   = CMD_BAD;
                        n_state = S_RESP;
                    end else begin
                        o_cmd   = CMD_FMATCH;
                        n_state = S_FPREV;
                    end
                end else if (st.last) begin
                    o_cmd   = CMD_BAD;
                    n_state = S_RESP;
                end else begin
                    o_cmd = CMD_NEXT;
                end
            end
            S_FPREV: begin
                o_cmd   = CMD_FPREV;
                n_state = S_FNEXT;
            end
            S_FNEXT: begin
                o_cmd   = CMD_FNEXT;
                n_state = S_FWR;
            end
            S_FWR: begin
                o_cmd   = CMD_FWR;
                n_state = st.has_shl ? S_FSHL : S_FFIN;
            end
            S_FSHL: begin
                o_cmd = CMD_FSHL;
                if (!st.shl_more) begin
                    n_state = S_FFIN;
                end
            end
            S_FFIN: begin
                o_cmd   = CMD_FFIN;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (st.out_free) begin
                    o_cmd   = CMD_RESP;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/first_fit_segment_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_segment_allocator: first-fit heap allocator with coalescing
// Address-ordered segment table with split on allocate and merge on free.
// ----------------------------------------------------------------------------
// One request is handled at a time. The segment table sits in a memory
// with one write and one registered read per cycle. An allocate walks the
// table from the first entry and either hands out an entry whole, finds
// nothing, or splits an entry; one that splits at any entry moves every
// later entry up by one at one entry per cycle. A free walks to the named
// entry, reads both neighbours, writes the merged entry and moves the
// later entries down. The result register frees the request side, so the
// next request is taken while a result waits.
// After reset, and at every heap_bytes write, the table holds one free
// segment; reset writes it in the S_INIT state before the first request.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ffsa_pkg::W_OFS-1:0]  i_cfg_data,
    input  wire logic                        i_req_valid,
    output logic                             o_req_stall,
    input  wire logic                        i_req_type,
    input  wire logic [ffsa_pkg::W_OFS-1:0]  i_req_size,
    input  wire logic [ffsa_pkg::W_ADDR-1:0] i_req_addr,
    output logic                             o_rsp_valid,
    input  wire logic                        i_rsp_stall,
    output logic [1:0]                       o_status,
    output logic [ffsa_pkg::W_ADDR-1:0]      o_result_addr,
    output logic [ffsa_pkg::W_OFS-1:0]       o_free_bytes
);
    import ffsa_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;
    logic       cfg_we;

    // heap size writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    ffsa_dpath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_dp_status   (dp_status),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_req_size    (i_req_size),
        .i_req_addr    (i_req_addr),
        .i_rsp_stall   (i_rsp_stall),
        .o_rsp_valid   (o_rsp_valid),
        .o_status      (o_status),
        .o_result_addr (o_result_addr),
        .o_free_bytes  (o_free_bytes)
    );

endmodule
`default_nettype wire

/* bench/first_fit_segment_allocator_test.sv */
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_test: self-checking bench for the allocator
// Drives allocate and free items against several heap sizes. A scoreboard
// class keeps its own segment table, predicts every result, and checks each
// result item field by field in order of arrival.
// ----------------------------------------------------------------------------
typedef struct {
    logic [1:0]  status;
    logic [24:0] addr;
    logic [25:0] free;
} t_alloc_result;

class heap_scoreboard;
    localparam int NSEG = 64;
    localparam int HDR  = 16;

    bit [63:0]     heap;
    bit [63:0]     start_q[NSEG];
    bit [63:0]     bytes_q[NSEG];
    bit            used_q[NSEG];
    int            count;
    bit [63:0]     free_total;
    t_alloc_result expected_q[$];
    int            errors;

    // rebuild the table as one free segment
    function void configure(bit [63:0] value);
        heap = value & 64'h3FFFFFF;
        for (int i = 0; i < NSEG; i++) begin
            start_q[i] = 0;
            bytes_q[i] = 0;
            used_q[i]  = 0;
        end
        bytes_q[0] = (heap > HDR) ? heap - HDR : 0;
        count      = 1;
        free_total = bytes_q[0];
    endfunction

    function void drop_entry(int k);
        for (int i = k; i + 1 < count; i++) begin
            start_q[i] = start_q[i + 1];
            bytes_q[i] = bytes_q[i + 1];
            used_q[i]  = used_q[i + 1];
        end
        count--;
    endfunction

    function void walk_alloc(bit [63:0] size, ref t_alloc_result r);
        bit [63:0] need;
        bit [63:0] roomy;
        if (size == 0) begin
            r.status = ffsa_pkg::ST_NOFIT;
            return;
        end
        need  = size + HDR;
        roomy = size + 2 * HDR;
        for (int i = 0; i < count; i++) begin
            if (used_q[i]) continue;
            if (bytes_q[i] >= need && bytes_q[i] <= roomy) begin
                used_q[i]  = 1;
                free_total -= bytes_q[i];
                r.addr = 25'(start_q[i] + HDR);
                return;
            end
            if (bytes_q[i] > roomy) begin
                if (count >= NSEG) begin
                    r.status = ffsa_pkg::ST_FULL;
                    return;
                end
                for (int j = count; j > i + 1; j--) begin
                    start_q[j] = start_q[j - 1];
                    bytes_q[j] = bytes_q[j - 1];
                    used_q[j]  = used_q[j - 1];
                end
                start_q[i + 1] = (start_q[i] + need) & 64'h3FFFFFF;
                bytes_q[i + 1] = bytes_q[i] - need;
                used_q[i + 1]  = 0;
                bytes_q[i]     = need;
                used_q[i]      = 1;
                count++;
                free_total -= need;
                r.addr = 25'(start_q[i] + HDR);
                return;
            end
        end
        r.status = ffsa_pkg::ST_NOFIT;
    endfunction

    function void release_seg(bit [63:0] addr, ref t_alloc_result r);
        int k;
        bit found;
        k     = 0;
        found = 0;
        if (addr == 0) return;
        for (int i = 0; i < count; i++) begin
            if (start_q[i] + HDR == addr) begin
                k     = i;
                found = 1;
                break;
            end
        end
        if (!found || !used_q[k]) begin
            r.status = ffsa_pkg::ST_BAD;
            return;
        end
        used_q[k]  = 0;
        free_total += bytes_q[k];
        if (k > 0 && !used_q[k - 1]) begin
            bytes_q[k - 1] += bytes_q[k];
            drop_entry(k);
            k--;
        end
        if (k + 1 < count && !used_q[k + 1]) begin
            bytes_q[k] += bytes_q[k + 1];
            drop_entry(k + 1);
        end
    endfunction

    // note one accepted request and queue its expected result
    function t_alloc_result note_request(bit kind, bit [25:0] size, bit [24:0] addr);
        t_alloc_result r;
        r.status = ffsa_pkg::ST_OK;
        r.addr   = '0;
        if (kind == 1'b0) walk_alloc(size, r);
        else release_seg(addr, r);
        r.free = 26'(free_total);
        expected_q.push_back(r);
        return r;
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(logic [1:0] st, logic [24:0] addr, logic [25:0] free);
        t_alloc_result e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result st=%0d addr=%0d free=%0d", $time, st, addr, free);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
        end
        if (addr !== e.addr) begin
            $display("%0t: result_addr expected %0d actual %0d", $time, e.addr, addr);
            errors++;
        end
        if (free !== e.free) begin
            $display("%0t: free_bytes expected %0d actual %0d", $time, e.free, free);
            errors++;
        end
    endfunction
endclass

module first_fit_segment_allocator_test;
    localparam bit REQ_ALLOC = 1'b0;
    localparam bit REQ_FREE  = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [25:0] i_cfg_data;
    logic        i_req_valid;
    logic        o_req_stall;
    logic        i_req_type;
    logic [25:0] i_req_size;
    logic [24:0] i_req_addr;
    logic        o_rsp_valid;
    logic        i_rsp_stall;
    logic [1:0]  o_status;
    logic [24:0] o_result_addr;
    logic [25:0] o_free_bytes;

    heap_scoreboard sb;
    bit [24:0] live_q[$];
    bit [24:0] freed_q[$];
    int hold_cycles;
    int stall_mode;
    bit sending;

    first_fit_segment_allocator #(.MAX_SEGMENTS(64), .HEADER_BYTES(16)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall),
        .i_req_type(i_req_type), .i_req_size(i_req_size), .i_req_addr(i_req_addr),
        .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall),
        .o_status(o_status), .o_result_addr(o_result_addr), .o_free_bytes(o_free_bytes)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    // offer one item and hold it until accepted
    task automatic send_item(bit kind, bit [25:0] size, bit [24:0] addr);
        t_alloc_result r;
        @(negedge i_clk);
        i_req_valid <= 1'b1;
        i_req_type  <= kind;
        i_req_size  <= size;
        i_req_addr  <= addr;
        forever begin
            @(posedge i_clk);
            if (!o_req_stall) break;
        end
        r = sb.note_request(kind, size, addr);
        if (kind == REQ_ALLOC && r.status == ffsa_pkg::ST_OK) live_q.push_back(r.addr);
    endtask

    task automatic idle_for(int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_req_valid <= 1'b0;
            repeat (n - 1) @(posedge i_clk);
        end
    endtask

    // drain all results, let the block settle, then write the heap size
    task automatic write_heap(bit [25:0] value);
        idle_for(1);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.configure(value);
        live_q.delete();
        freed_q.delete();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // pick one random request, mostly well formed
    task automatic send_random(int alloc_pct);
        int pick;
        int idx;
        bit [25:0] size;
        bit [24:0] addr;
        int hi;
        size = 26'($urandom);
        addr = 25'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct || live_q.size() == 0) begin
            hi   = (sb.heap / 40 > 1) ? int'(sb.heap / 40) : 1;
            pick = $urandom_range(0, 99);
            if (pick < 80) size = 26'($urandom_range(1, hi));
            else if (pick < 86) size = 0;
            else if (pick < 93) size = 26'($urandom);
            else size = 26'($urandom_range(1, int'(sb.heap)));
            send_item(REQ_ALLOC, size, addr);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                idx  = $urandom_range(0, live_q.size() - 1);
                addr = live_q[idx];
                live_q.delete(idx);
                freed_q.push_back(addr);
            end else if (pick < 85 && freed_q.size() != 0) begin
                addr = freed_q[$urandom_range(0, freed_q.size() - 1)];
            end else if (pick < 92) begin
                addr = 0;
            end
            send_item(REQ_FREE, size, addr);
        end
    endtask

    // receiver: check results and stall on its own pattern
    initial begin
        i_rsp_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_rsp_valid && !i_rsp_stall)
                sb.check_result(o_status, o_result_addr, o_free_bytes);
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_rsp_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_rsp_stall <= 1'b0;
                    1: i_rsp_stall <= ($urandom_range(0, 99) < 30);
                    default: i_rsp_stall <= ($urandom_range(0, 99) < 75);
                endcase
                if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            end
        end
    end

    initial begin
        bit [25:0] heaps[6];
        int burst;
        bit [24:0] a1;
        bit [24:0] a2;
        bit [24:0] a3;
        heaps = '{26'd64, 26'd33554432, 26'd4096, 26'd1000, 26'd65536, 26'd33554432};
        sb          = new();
        sb.configure(ffsa_pkg::HEAP_DEFAULT);
        hold_cycles = 0;
        stall_mode  = 1;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_req_valid = 1'b0;
        i_req_type  = 1'b0;
        i_req_size  = '0;
        i_req_addr  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero size, no fit, whole fit, null and bad frees, merges
        send_item(REQ_ALLOC, 26'd0, 25'h1FFFFFF);
        send_item(REQ_ALLOC, 26'd33554432, 25'd0);
        send_item(REQ_ALLOC, 26'd33554400, 25'd0);
        send_item(REQ_ALLOC, 26'd1, 25'd0);
        send_item(REQ_FREE, 26'h3FFFFFF, 25'd0);
        send_item(REQ_FREE, 26'd0, 25'd16);
        send_item(REQ_FREE, 26'd0, 25'd16);
        send_item(REQ_FREE, 26'd0, 25'h1FFFFFF);
        send_item(REQ_ALLOC, 26'd100, 25'd0);
        send_item(REQ_ALLOC, 26'd200, 25'd0);
        send_item(REQ_ALLOC, 26'd300, 25'd0);
        a1 = 25'd16;
        a2 = 25'd132;
        a3 = 25'd348;
        send_item(REQ_FREE, 26'd0, a2);
        send_item(REQ_FREE, 26'd0, a1);
        send_item(REQ_FREE, 26'd0, a3);
        write_heap(26'd64);
        send_item(REQ_ALLOC, 26'd15, 25'd0);
        send_item(REQ_ALLOC, 26'd1, 25'd0);
        send_item(REQ_FREE, 26'd0, 25'd16);
        send_item(REQ_ALLOC, 26'd16, 25'd0);
        send_item(REQ_ALLOC, 26'd1, 25'd0);

        // random phases over several heap sizes
        for (int ph = 0; ph < 6; ph++) begin
            write_heap(heaps[ph]);
            if (ph == 1) hold_cycles = 3000;
            for (int n = 0; n < 130; ) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++) begin
                    send_random((ph == 5) ? 90 : 60);
                    n++;
                end
                if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 15));
            end
        end

        idle_for(1);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
